// ----- hw/rtl/point_in_convex_polygon_unit_defines.svh -----
// Assertion macros shared by the checker of point_in_convex_polygon_unit.
// No dependencies.
`ifndef POINT_IN_CONVEX_POLYGON_UNIT_DEFINES_SVH
`define POINT_IN_CONVEX_POLYGON_UNIT_DEFINES_SVH

// check a consequent in the cycle after the antecedent
`define PIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pic assertion failed");

// check a consequent in the same cycle as the antecedent
`define PIC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pic assertion failed");

`endif

// ----- hw/rtl/pic_pkg.sv -----
// Types, codes and constants of the point-in-convex-polygon unit.
// No dependencies.
package pic_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_BITS_DEF   = 16;
    localparam int FIELD_W          = 16;
    localparam int EPS_SINE_W       = 16;
    localparam int EPS_DIST_W       = 15;
    localparam int PADDR_W          = 3;
    localparam int PDATA_W          = 32;

    localparam logic [EPS_SINE_W-1:0] EPS_SINE_RST = 16'd7;
    localparam logic [EPS_DIST_W-1:0] EPS_DIST_RST = 15'd1;

    typedef enum logic [0:0] {
        REG_EPS_SINE = 1'b0,
        REG_EPS_DIST = 1'b1
    } pic_reg_e;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_TEST   = 2'd2
    } pic_func_e;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [FIELD_W-1:0] coord_x;
        logic signed [FIELD_W-1:0] coord_y;
    } pic_in_t;

    typedef struct packed {
        logic inside_res;
        logic overflowed;
    } pic_out_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ES2, OP_ED2, OP_LOAD_A, OP_LOAD_B,
        OP_NA0, OP_NA1, OP_NAB0, OP_NAB1, OP_NB0, OP_NB1,
        OP_AB0, OP_AB1, OP_DOT0, OP_DOT1, OP_SCR0, OP_SCR1,
        OP_CR0, OP_CR1, OP_SQ, OP_SR, OP_T, OP_R0, OP_R1, OP_SHIFT
    } pic_op_e;

    typedef struct packed {
        logic    accept;
        pic_op_e op;
    } pic_cmd_t;

    typedef struct packed {
        logic near;
        logic dot_nonneg;
        logic past_end;
        logic seg_in;
        logic sine_pos;
        logic sine_neg;
        logic overflow;
    } pic_status_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_START, ST_A, ST_NA0, ST_NA1, ST_B,
        ST_DOT0, ST_DOT1, ST_AB0, ST_AB1, ST_SEL,
        ST_NEAR0, ST_NEAR1, ST_NEAR_DEC,
        ST_SCR0, ST_SCR1, ST_SSQ, ST_SR, ST_SEG_DEC,
        ST_NB0, ST_NB1, ST_CR0, ST_CR1, ST_SQ, ST_T, ST_R0, ST_R1, ST_TURN,
        ST_DONE
    } pic_state_e;

endpackage

// ----- hw/rtl/pic_datapath.sv -----
// Datapath of the point-in-convex-polygon unit: vertex memory, shared multiplier,
// work registers and compares. Depends on pic_pkg.
module pic_datapath #(
    parameter int MAX_VERTICES = pic_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pic_pkg::COORD_BITS_DEF,
    localparam int AW = $clog2(MAX_VERTICES),
    localparam int CW = AW + 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pic_pkg::pic_cmd_t                  cmd,
    input  logic [AW-1:0]                      rd_addr,
    input  pic_pkg::pic_in_t                   in_item,
    input  logic [pic_pkg::EPS_SINE_W-1:0]     eps_sine,
    input  logic [pic_pkg::EPS_DIST_W-1:0]     eps_dist,
    output pic_pkg::pic_status_t               status,
    output logic [CW-1:0]                      count
);

    localparam int C  = COORD_BITS;
    localparam int D  = C + 1;
    localparam int MW = (2 * C + 3 > 33) ? 2 * C + 3 : 33;
    localparam int PW = 2 * MW;
    localparam int WW = 2 * MW + 32;

    logic [C-1:0] vx_mem [MAX_VERTICES];
    logic [C-1:0] vy_mem [MAX_VERTICES];
    logic [C-1:0] rdx_reg, rdy_reg;
    logic [C-1:0] px_reg, py_reg;
    logic [CW-1:0] count_reg;
    logic          ovf_reg;

    logic signed [D-1:0]  ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [MW-1:0] na_reg, nb_reg, e2_reg, cr_reg, dot_reg;
    logic signed [PW-1:0] t_reg;
    logic [WW-1:0]        w1_reg, w2_reg;

    logic [31:0]          x_ext, y_ext;
    logic [C-1:0]         x_c, y_c;
    logic signed [D-1:0]  dx, dy;
    logic signed [D:0]    abx, aby;
    logic signed [MW-1:0] ma, mb, t_lo, t_hi;
    logic signed [PW-1:0] prod;
    logic signed [MW:0]   end_sum;
    logic [WW-1:0]        lhs;
    logic                 turn;

    assign x_ext = {16'b0, in_item.coord_x};
    assign y_ext = {16'b0, in_item.coord_y};
    assign x_c   = x_ext[C-1:0];
    assign y_c   = y_ext[C-1:0];

    assign dx   = D'(signed'(rdx_reg)) - D'(signed'(px_reg));
    assign dy   = D'(signed'(rdy_reg)) - D'(signed'(py_reg));
    assign abx  = (D+1)'(bx_reg) - (D+1)'(ax_reg);
    assign aby  = (D+1)'(by_reg) - (D+1)'(ay_reg);
    assign t_lo = signed'({1'b0, t_reg[MW-2:0]});
    assign t_hi = signed'({1'b0, t_reg[PW-3:MW-1]});

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            pic_pkg::OP_ES2: begin
                ma = signed'(MW'(eps_sine));
                mb = signed'(MW'(eps_sine));
            end
            pic_pkg::OP_ED2: begin
                ma = signed'(MW'(eps_dist));
                mb = signed'(MW'(eps_dist));
            end
            pic_pkg::OP_NA0: begin
                ma = MW'(ax_reg);
                mb = MW'(ax_reg);
            end
            pic_pkg::OP_NA1: begin
                ma = MW'(ay_reg);
                mb = MW'(ay_reg);
            end
            pic_pkg::OP_NAB0, pic_pkg::OP_NB0: begin
                ma = MW'(bx_reg);
                mb = MW'(bx_reg);
            end
            pic_pkg::OP_NAB1, pic_pkg::OP_NB1: begin
                ma = MW'(by_reg);
                mb = MW'(by_reg);
            end
            pic_pkg::OP_AB0: begin
                ma = MW'(abx);
                mb = MW'(abx);
            end
            pic_pkg::OP_AB1: begin
                ma = MW'(aby);
                mb = MW'(aby);
            end
            pic_pkg::OP_DOT0: begin
                ma = MW'(abx);
                mb = MW'(ax_reg);
            end
            pic_pkg::OP_DOT1: begin
                ma = MW'(aby);
                mb = MW'(ay_reg);
            end
            pic_pkg::OP_SCR0: begin
                ma = MW'(abx);
                mb = MW'(ay_reg);
            end
            pic_pkg::OP_SCR1: begin
                ma = MW'(aby);
                mb = MW'(ax_reg);
            end
            pic_pkg::OP_CR0: begin
                ma = MW'(bx_reg);
                mb = MW'(ay_reg);
            end
            pic_pkg::OP_CR1: begin
                ma = MW'(ax_reg);
                mb = MW'(by_reg);
            end
            pic_pkg::OP_SQ: begin
                ma = cr_reg;
                mb = cr_reg;
            end
            pic_pkg::OP_SR: begin
                ma = e2_reg;
                mb = nb_reg;
            end
            pic_pkg::OP_T: begin
                ma = e2_reg;
                mb = na_reg;
            end
            pic_pkg::OP_R0: begin
                ma = t_lo;
                mb = nb_reg;
            end
            pic_pkg::OP_R1: begin
                ma = t_hi;
                mb = nb_reg;
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = ma * mb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (cmd.accept) begin
            if (in_item.func == pic_pkg::FUNC_CLEAR) begin
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end else if (in_item.func == pic_pkg::FUNC_APPEND) begin
                if (count_reg < CW'(MAX_VERTICES)) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && in_item.func == pic_pkg::FUNC_APPEND
                && count_reg < CW'(MAX_VERTICES)) begin
            vx_mem[count_reg[AW-1:0]] <= x_c;
            vy_mem[count_reg[AW-1:0]] <= y_c;
        end
        rdx_reg <= vx_mem[rd_addr];
        rdy_reg <= vy_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && in_item.func == pic_pkg::FUNC_TEST) begin
            px_reg <= x_c;
            py_reg <= y_c;
        end
        case (cmd.op)
            pic_pkg::OP_ES2, pic_pkg::OP_ED2: e2_reg <= MW'(prod);
            pic_pkg::OP_LOAD_A: begin
                ax_reg <= dx;
                ay_reg <= dy;
            end
            pic_pkg::OP_LOAD_B: begin
                bx_reg <= dx;
                by_reg <= dy;
            end
            pic_pkg::OP_NA0, pic_pkg::OP_NAB0: na_reg <= MW'(prod);
            pic_pkg::OP_NA1, pic_pkg::OP_NAB1: na_reg <= na_reg + MW'(prod);
            pic_pkg::OP_NB0, pic_pkg::OP_AB0:  nb_reg <= MW'(prod);
            pic_pkg::OP_NB1, pic_pkg::OP_AB1:  nb_reg <= nb_reg + MW'(prod);
            pic_pkg::OP_DOT0: dot_reg <= MW'(prod);
            pic_pkg::OP_DOT1: dot_reg <= dot_reg + MW'(prod);
            pic_pkg::OP_SCR0, pic_pkg::OP_CR0: cr_reg <= MW'(prod);
            pic_pkg::OP_SCR1, pic_pkg::OP_CR1: cr_reg <= cr_reg - MW'(prod);
            pic_pkg::OP_SQ:   w1_reg <= WW'(prod);
            pic_pkg::OP_SR:   w2_reg <= WW'(prod);
            pic_pkg::OP_T:    t_reg  <= prod;
            pic_pkg::OP_R0:   w2_reg <= WW'(prod);
            pic_pkg::OP_R1:   w2_reg <= w2_reg + (WW'(prod) << (MW - 1));
            pic_pkg::OP_SHIFT: begin
                ax_reg <= bx_reg;
                ay_reg <= by_reg;
                na_reg <= nb_reg;
            end
            default: ;
        endcase
    end

    assign end_sum = (MW+1)'(dot_reg) + (MW+1)'(nb_reg);
    assign lhs     = w1_reg << 32;
    assign turn    = w2_reg < lhs;

    always_comb begin
        status.near       = na_reg < e2_reg;
        status.dot_nonneg = !dot_reg[MW-1];
        status.past_end   = end_sum <= 0;
        status.seg_in     = w1_reg < w2_reg;
        status.sine_pos   = turn && (cr_reg > 0);
        status.sine_neg   = turn && (cr_reg < 0);
        status.overflow   = ovf_reg;
    end

    assign count = count_reg;

endmodule

// ----- hw/rtl/pic_ctrl.sv -----
// Controller of the point-in-convex-polygon unit: handshakes, test sequencer
// and result register. Depends on pic_pkg.
module pic_ctrl #(
    parameter int MAX_VERTICES = pic_pkg::MAX_VERTICES_DEF,
    localparam int AW = $clog2(MAX_VERTICES),
    localparam int CW = AW + 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            func,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pic_pkg::pic_out_t     m_data,
    output pic_pkg::pic_cmd_t     cmd,
    output logic [AW-1:0]         rd_addr,
    input  logic [CW-1:0]         count,
    input  pic_pkg::pic_status_t  status
);

    pic_pkg::pic_state_e state_reg, state_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic [CW-1:0]       pair_reg, pair_next;
    logic                pos_reg, pos_next, neg_reg, neg_next;
    logic                near_b_reg, near_b_next;
    logic                res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    pic_pkg::pic_out_t   m_data_reg, m_data_next;
    logic                accept;
    logic [CW-1:0]       addr_inc;

    assign s_ready  = (state_reg == pic_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign addr_inc = CW'(addr_reg) + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pic_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg   <= addr_next;
        pair_reg   <= pair_next;
        pos_reg    <= pos_next;
        neg_reg    <= neg_next;
        near_b_reg <= near_b_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        pair_next    = pair_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        near_b_next  = near_b_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        cmd.accept   = accept;
        cmd.op       = pic_pkg::OP_NONE;
        unique case (state_reg)
            pic_pkg::ST_IDLE: begin
                if (accept && func == pic_pkg::FUNC_TEST) begin
                    addr_next  = '0;
                    state_next = pic_pkg::ST_START;
                end
            end
            pic_pkg::ST_START: begin
                pair_next = '0;
                pos_next  = 1'b0;
                neg_next  = 1'b0;
                addr_next = AW'(1);
                cmd.op    = (count > CW'(2)) ? pic_pkg::OP_ES2 : pic_pkg::OP_ED2;
                if (count == '0) begin
                    res_next   = 1'b0;
                    state_next = pic_pkg::ST_DONE;
                end else begin
                    state_next = pic_pkg::ST_A;
                end
            end
            pic_pkg::ST_A: begin
                cmd.op     = pic_pkg::OP_LOAD_A;
                state_next = (count == CW'(2)) ? pic_pkg::ST_B : pic_pkg::ST_NA0;
            end
            pic_pkg::ST_NA0: begin
                cmd.op     = pic_pkg::OP_NA0;
                state_next = pic_pkg::ST_NA1;
            end
            pic_pkg::ST_NA1: begin
                cmd.op     = pic_pkg::OP_NA1;
                state_next = (count == CW'(1)) ? pic_pkg::ST_NEAR_DEC : pic_pkg::ST_B;
            end
            pic_pkg::ST_B: begin
                cmd.op     = pic_pkg::OP_LOAD_B;
                addr_next  = (addr_inc == count) ? '0 : addr_inc[AW-1:0];
                state_next = (count == CW'(2)) ? pic_pkg::ST_DOT0 : pic_pkg::ST_NB0;
            end
            pic_pkg::ST_DOT0: begin
                cmd.op     = pic_pkg::OP_DOT0;
                state_next = pic_pkg::ST_DOT1;
            end
            pic_pkg::ST_DOT1: begin
                cmd.op     = pic_pkg::OP_DOT1;
                state_next = pic_pkg::ST_AB0;
            end
            pic_pkg::ST_AB0: begin
                cmd.op     = pic_pkg::OP_AB0;
                state_next = pic_pkg::ST_AB1;
            end
            pic_pkg::ST_AB1: begin
                cmd.op     = pic_pkg::OP_AB1;
                state_next = pic_pkg::ST_SEL;
            end
            pic_pkg::ST_SEL: begin
                if (status.dot_nonneg) begin
                    near_b_next = 1'b0;
                    state_next  = pic_pkg::ST_NEAR0;
                end else if (status.past_end) begin
                    near_b_next = 1'b1;
                    state_next  = pic_pkg::ST_NEAR0;
                end else begin
                    state_next = pic_pkg::ST_SCR0;
                end
            end
            pic_pkg::ST_NEAR0: begin
                cmd.op     = near_b_reg ? pic_pkg::OP_NAB0 : pic_pkg::OP_NA0;
                state_next = pic_pkg::ST_NEAR1;
            end
            pic_pkg::ST_NEAR1: begin
                cmd.op     = near_b_reg ? pic_pkg::OP_NAB1 : pic_pkg::OP_NA1;
                state_next = pic_pkg::ST_NEAR_DEC;
            end
            pic_pkg::ST_NEAR_DEC: begin
                res_next   = status.near;
                state_next = pic_pkg::ST_DONE;
            end
            pic_pkg::ST_SCR0: begin
                cmd.op     = pic_pkg::OP_SCR0;
                state_next = pic_pkg::ST_SCR1;
            end
            pic_pkg::ST_SCR1: begin
                cmd.op     = pic_pkg::OP_SCR1;
                state_next = pic_pkg::ST_SSQ;
            end
            pic_pkg::ST_SSQ: begin
                cmd.op     = pic_pkg::OP_SQ;
                state_next = pic_pkg::ST_SR;
            end
            pic_pkg::ST_SR: begin
                cmd.op     = pic_pkg::OP_SR;
                state_next = pic_pkg::ST_SEG_DEC;
            end
            pic_pkg::ST_SEG_DEC: begin
                res_next   = status.seg_in;
                state_next = pic_pkg::ST_DONE;
            end
            pic_pkg::ST_NB0: begin
                cmd.op     = pic_pkg::OP_NB0;
                state_next = pic_pkg::ST_NB1;
            end
            pic_pkg::ST_NB1: begin
                cmd.op     = pic_pkg::OP_NB1;
                state_next = pic_pkg::ST_CR0;
            end
            pic_pkg::ST_CR0: begin
                cmd.op     = pic_pkg::OP_CR0;
                state_next = pic_pkg::ST_CR1;
            end
            pic_pkg::ST_CR1: begin
                cmd.op     = pic_pkg::OP_CR1;
                state_next = pic_pkg::ST_SQ;
            end
            pic_pkg::ST_SQ: begin
                cmd.op     = pic_pkg::OP_SQ;
                state_next = pic_pkg::ST_T;
            end
            pic_pkg::ST_T: begin
                cmd.op     = pic_pkg::OP_T;
                state_next = pic_pkg::ST_R0;
            end
            pic_pkg::ST_R0: begin
                cmd.op     = pic_pkg::OP_R0;
                state_next = pic_pkg::ST_R1;
            end
            pic_pkg::ST_R1: begin
                cmd.op     = pic_pkg::OP_R1;
                state_next = pic_pkg::ST_TURN;
            end
            pic_pkg::ST_TURN: begin
                pos_next = pos_reg || status.sine_pos;
                neg_next = neg_reg || status.sine_neg;
                if (pair_reg == count - 1'b1) begin
                    res_next   = !(pos_next && neg_next);
                    state_next = pic_pkg::ST_DONE;
                end else begin
                    // advance: this pair's far vertex becomes the near one
                    cmd.op     = pic_pkg::OP_SHIFT;
                    pair_next  = pair_reg + 1'b1;
                    state_next = pic_pkg::ST_B;
                end
            end
            pic_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.inside_res = res_reg;
                    m_data_next.overflowed = status.overflow;
                    state_next             = pic_pkg::ST_IDLE;
                end
            end
            default: state_next = pic_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign rd_addr = addr_reg;

endmodule

// ----- hw/rtl/point_in_convex_polygon_unit.sv -----
// Top level of the point-in-convex-polygon unit: configuration registers and
// the controller/datapath pair. Depends on pic_pkg, pic_ctrl, pic_datapath.
//
// Input channel s_valid/s_ready/s_data carries one request: clear the outline,
// append a vertex or test a point (Q7.8 coordinates). Only a test gives a
// result on m_valid/m_ready/m_data: the inside flag and the sticky overflow
// flag. Clear and append leave the unit ready for the next request. A test's
// result passes through the output register. The test walks the vertex pairs
// through one shared multiplier, ten steps per pair; that multiplier and the
// one-read vertex memory set the length of a test.
// One test is in flight at a time. A finished result waits in the output
// register while the next request is taken; a second test finishing while the
// receiver stalls holds until the register empties.
// The APB port writes eps_sine at 0x0 and eps_distance at 0x4; write it only
// while idle. Reset empties the outline, clears the overflow flag and the
// output register and restores eps_sine = 7, eps_distance = 1.
module point_in_convex_polygon_unit #(
    parameter int MAX_VERTICES = pic_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pic_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pic_pkg::pic_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pic_pkg::pic_out_t             m_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pic_pkg::PADDR_W-1:0]   paddr,
    input  logic [pic_pkg::PDATA_W-1:0]   pwdata,
    output logic [pic_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = AW + 1;

    logic [pic_pkg::EPS_SINE_W-1:0] eps_sine_reg;
    logic [pic_pkg::EPS_DIST_W-1:0] eps_dist_reg;
    logic                           wr_en;
    pic_pkg::pic_cmd_t              cmd;
    pic_pkg::pic_status_t           status;
    logic [AW-1:0]                  rd_addr;
    logic [CW-1:0]                  count;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_sine_reg <= pic_pkg::EPS_SINE_RST;
            eps_dist_reg <= pic_pkg::EPS_DIST_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                pic_pkg::REG_EPS_SINE: eps_sine_reg <= pwdata[pic_pkg::EPS_SINE_W-1:0];
                pic_pkg::REG_EPS_DIST: eps_dist_reg <= pwdata[pic_pkg::EPS_DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pic_pkg::REG_EPS_SINE: prdata = pic_pkg::PDATA_W'(eps_sine_reg);
            pic_pkg::REG_EPS_DIST: prdata = pic_pkg::PDATA_W'(eps_dist_reg);
            default:               prdata = '0;
        endcase
    end

    pic_ctrl #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .func    (s_data.func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .count   (count),
        .status  (status)
    );

    pic_datapath #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .in_item  (s_data),
        .eps_sine (eps_sine_reg),
        .eps_dist (eps_dist_reg),
        .status   (status),
        .count    (count)
    );

endmodule

// ----- hw/rtl/pic_checker.sv -----
// Port-level assertions for point_in_convex_polygon_unit and their bind.
// Depends on pic_pkg and point_in_convex_polygon_unit_defines.svh.
`include "point_in_convex_polygon_unit_defines.svh"

module pic_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input pic_pkg::pic_in_t              s_data,
    input logic                          m_valid,
    input logic                          m_ready,
    input pic_pkg::pic_out_t             m_data,
    input logic                          psel,
    input logic                          pready
);

    `PIC_ASSERT_NEXT(a_reset_empties_output, aclk, 1'b1, !aresetn, !m_valid)
    `PIC_ASSERT_NEXT(a_stalled_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `PIC_ASSERT_NEXT(a_test_blocks_input, aclk, aresetn, s_valid && s_ready && s_data.func == pic_pkg::FUNC_TEST, !s_ready)
    `PIC_ASSERT_NOW(a_no_wait_states, aclk, aresetn, psel, pready)

endmodule

bind point_in_convex_polygon_unit pic_checker u_pic_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .pready  (pready)
);
